[rtl/qsoc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsoc_pkg
// Shared widths, limits and defaults of the quicksort unit.
// ----------------------------------------------------------------------------
package qsoc_pkg;

    localparam int DEF_MAX_ELEMENTS = 32;
    localparam int DEF_VALUE_WIDTH  = 32;

    localparam int DATA_W      = 32;
    localparam int CMP_W       = 12;
    localparam int MOV_W       = 8;
    localparam int OUT_PAD_W   = 4;
    localparam int OUT_TDATA_W = DATA_W + CMP_W + MOV_W + OUT_PAD_W;

    localparam logic [CMP_W-1:0] CMP_MAX = '1;
    localparam logic [MOV_W-1:0] MOV_MAX = '1;

endpackage

[rtl/qsoc_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsoc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module qsoc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/quicksort_with_op_counts_unit.sv]
`timescale 1ns / 1ps
// load: one input item per cycle; the unit stays ready until the last item is taken
// sort: comparisons read the element RAM through its single read port, and a comparison
// is also counted where a bound ends a scan; swaps and pivot moves use its write port
// emit: each result item is read from the element RAM and held until the sink takes it
// reset: asynchronous, empty set and zero counts; RAM contents are not cleared
// ----------------------------------------------------------------------------
// quicksort_with_op_counts_unit
// Loads a set of signed values, sorts it by quicksort with an explicit range
// stack, and emits the sorted values with comparison and swap counts.
// ----------------------------------------------------------------------------
module quicksort_with_op_counts_unit #(
    parameter int MAX_ELEMENTS = qsoc_pkg::DEF_MAX_ELEMENTS,
    parameter int VALUE_WIDTH  = qsoc_pkg::DEF_VALUE_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [qsoc_pkg::DATA_W-1:0]      s_tdata,   // value
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [qsoc_pkg::OUT_TDATA_W-1:0] m_tdata,   // sorted_value, compare_total, move_total
    output logic                             m_tlast
);

    import qsoc_pkg::*;

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int IW = AW + 2;
    localparam int VW = VALUE_WIDTH;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_INIT,
        ST_POP,
        ST_POP_WAIT,
        ST_PIV_WAIT,
        ST_OUTER,
        ST_SCAN_I,
        ST_CMP_I,
        ST_SCAN_J,
        ST_CMP_J,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_FIN_A,
        ST_FIN_B,
        ST_PUSH_A,
        ST_PUSH_B,
        ST_EMIT_RD,
        ST_EMIT_WAIT,
        ST_EMIT_HOLD
    } state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          sp_reg, sp_next;
    logic [AW-1:0]          lo_reg, lo_next;
    logic [AW-1:0]          hi_reg, hi_next;
    logic signed [IW-1:0]   i_reg, i_next;
    logic signed [IW-1:0]   j_reg, j_next;
    logic [VW-1:0]          pivot_reg, pivot_next;
    logic [VW-1:0]          vi_reg, vi_next;
    logic [VW-1:0]          vj_reg, vj_next;
    logic [CMP_W-1:0]       cmp_reg, cmp_next;
    logic [MOV_W-1:0]       mov_reg, mov_next;
    logic [AW-1:0]          k_reg, k_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic                   m_last_reg, m_last_next;
    logic [DATA_W-1:0]      m_value_reg, m_value_next;

    logic                   st_we;
    logic [AW-1:0]          st_waddr;
    logic [VW-1:0]          st_wdata;
    logic [AW-1:0]          st_raddr;
    logic [VW-1:0]          st_rdata;

    logic                   stk_we;
    logic [AW-1:0]          stk_waddr;
    logic [2*AW-1:0]        stk_wdata;
    logic [AW-1:0]          stk_raddr;
    logic [2*AW-1:0]        stk_rdata;

    logic                   cmp_inc;
    logic                   mov_inc;
    logic [VW-1:0]          in_value;
    logic [DATA_W-1:0]      out_value;
    logic signed [IW-1:0]   lo_s, hi_s;
    logic signed [IW-1:0]   push_lo, push_hi;
    logic                   left_first;
    logic                   do_push;
    logic                   stack_room;

    function automatic logic stack_room_load(input logic [CW-1:0] cnt);
        stack_room_load = cnt < CW'(MAX_ELEMENTS);
    endfunction

    generate
        if (VW >= DATA_W)
        begin : g_wide
            assign in_value  = VW'(s_tdata);
            assign out_value = st_rdata[DATA_W-1:0];
        end
        else
        begin : g_narrow
            assign in_value  = s_tdata[VW-1:0];
            assign out_value = {{(DATA_W - VW){st_rdata[VW-1]}}, st_rdata};
        end
    endgenerate

    assign lo_s       = $signed({2'b00, lo_reg});
    assign hi_s       = $signed({2'b00, hi_reg});
    assign left_first = (j_reg - lo_s) > (hi_s - j_reg);
    assign stack_room = sp_reg < CW'(MAX_ELEMENTS);

    // first push takes the larger side, second the smaller
    always_comb
    begin
        if ((state_reg == ST_PUSH_A) == left_first)
        begin
            push_lo = lo_s;
            push_hi = j_reg - IW'(1);
        end
        else
        begin
            push_lo = j_reg + IW'(1);
            push_hi = hi_s;
        end
    end

    assign do_push   = (push_lo < push_hi) && stack_room;
    assign stk_raddr = AW'(sp_reg - CW'(1));

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        sp_next       = sp_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        pivot_next    = pivot_reg;
        vi_next       = vi_reg;
        vj_next       = vj_reg;
        k_next        = k_reg;
        m_tvalid_next = m_tvalid_reg;
        m_last_next   = m_last_reg;
        m_value_next  = m_value_reg;
        cmp_inc       = 1'b0;
        mov_inc       = 1'b0;
        st_we         = 1'b0;
        st_waddr      = count_reg[AW-1:0];
        st_wdata      = in_value;
        st_raddr      = i_reg[AW-1:0];
        stk_we        = 1'b0;
        stk_waddr     = sp_reg[AW-1:0];
        stk_wdata     = {push_hi[AW-1:0], push_lo[AW-1:0]};

        unique case (state_reg)
            ST_LOAD:
            begin
                if (s_tvalid)
                begin
                    if (stack_room_load(count_reg))
                    begin
                        st_we      = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    if (s_tlast)
                    begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT:
            begin
                if (count_reg > CW'(1))
                begin
                    stk_we    = 1'b1;
                    stk_waddr = '0;
                    stk_wdata = {AW'(count_reg - CW'(1)), AW'(0)};
                    sp_next   = CW'(1);
                end
                else
                begin
                    sp_next = '0;
                end
                state_next = ST_POP;
            end
            ST_POP:
            begin
                if (sp_reg == '0)
                begin
                    k_next     = '0;
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    sp_next    = sp_reg - CW'(1);
                    state_next = ST_POP_WAIT;
                end
            end
            ST_POP_WAIT:
            begin
                lo_next    = stk_rdata[AW-1:0];
                hi_next    = stk_rdata[2*AW-1:AW];
                st_raddr   = stk_rdata[AW-1:0];
                state_next = ST_PIV_WAIT;
            end
            ST_PIV_WAIT:
            begin
                pivot_next = st_rdata;
                i_next     = lo_s + IW'(1);
                j_next     = hi_s;
                state_next = ST_OUTER;
            end
            ST_OUTER:
            begin
                state_next = (i_reg <= j_reg) ? ST_SCAN_I : ST_FIN_A;
            end
            ST_SCAN_I:
            begin
                st_raddr = i_reg[AW-1:0];
                if (i_reg <= hi_s)
                begin
                    state_next = ST_CMP_I;
                end
                else
                begin
                    cmp_inc    = 1'b1;
                    state_next = ST_SCAN_J;
                end
            end
            ST_CMP_I:
            begin
                cmp_inc = 1'b1;
                if ($signed(st_rdata) <= $signed(pivot_reg))
                begin
                    i_next     = i_reg + IW'(1);
                    state_next = ST_SCAN_I;
                end
                else
                begin
                    vi_next    = st_rdata;
                    state_next = ST_SCAN_J;
                end
            end
            ST_SCAN_J:
            begin
                st_raddr = j_reg[AW-1:0];
                if (j_reg >= lo_s)
                begin
                    state_next = ST_CMP_J;
                end
                else
                begin
                    cmp_inc    = 1'b1;
                    state_next = (i_reg < j_reg) ? ST_SWAP_A : ST_OUTER;
                end
            end
            ST_CMP_J:
            begin
                cmp_inc = 1'b1;
                if ($signed(st_rdata) > $signed(pivot_reg))
                begin
                    j_next     = j_reg - IW'(1);
                    state_next = ST_SCAN_J;
                end
                else
                begin
                    vj_next    = st_rdata;
                    state_next = (i_reg < j_reg) ? ST_SWAP_A : ST_OUTER;
                end
            end
            ST_SWAP_A:
            begin
                st_we      = 1'b1;
                st_waddr   = i_reg[AW-1:0];
                st_wdata   = vj_reg;
                state_next = ST_SWAP_B;
            end
            ST_SWAP_B:
            begin
                st_we      = 1'b1;
                st_waddr   = j_reg[AW-1:0];
                st_wdata   = vi_reg;
                mov_inc    = 1'b1;
                state_next = ST_OUTER;
            end
            ST_FIN_A:
            begin
                if (lo_s < j_reg)
                begin
                    st_we      = 1'b1;
                    st_waddr   = lo_reg;
                    st_wdata   = vj_reg;
                    state_next = ST_FIN_B;
                end
                else
                begin
                    state_next = ST_PUSH_A;
                end
            end
            ST_FIN_B:
            begin
                st_we      = 1'b1;
                st_waddr   = j_reg[AW-1:0];
                st_wdata   = pivot_reg;
                mov_inc    = 1'b1;
                state_next = ST_PUSH_A;
            end
            ST_PUSH_A:
            begin
                if (do_push)
                begin
                    stk_we  = 1'b1;
                    sp_next = sp_reg + CW'(1);
                end
                state_next = ST_PUSH_B;
            end
            ST_PUSH_B:
            begin
                if (do_push)
                begin
                    stk_we  = 1'b1;
                    sp_next = sp_reg + CW'(1);
                end
                state_next = ST_POP;
            end
            ST_EMIT_RD:
            begin
                st_raddr   = k_reg;
                state_next = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT:
            begin
                m_value_next  = out_value;
                m_last_next   = (CW'(k_reg) + CW'(1)) == count_reg;
                m_tvalid_next = 1'b1;
                state_next    = ST_EMIT_HOLD;
            end
            ST_EMIT_HOLD:
            begin
                if (m_tready)
                begin
                    m_tvalid_next = 1'b0;
                    if (m_last_reg)
                    begin
                        count_next = '0;
                        sp_next    = '0;
                        k_next     = '0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + AW'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        cmp_next = cmp_reg;
        mov_next = mov_reg;
        if (state_reg == ST_EMIT_HOLD && m_tready && m_last_reg)
        begin
            cmp_next = '0;
            mov_next = '0;
        end
        else
        begin
            if (cmp_inc && cmp_reg != CMP_MAX)
            begin
                cmp_next = cmp_reg + CMP_W'(1);
            end
            if (mov_inc && mov_reg != MOV_MAX)
            begin
                mov_next = mov_reg + MOV_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            sp_reg       <= '0;
            lo_reg       <= '0;
            hi_reg       <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            pivot_reg    <= '0;
            vi_reg       <= '0;
            vj_reg       <= '0;
            cmp_reg      <= '0;
            mov_reg      <= '0;
            k_reg        <= '0;
            m_tvalid_reg <= 1'b0;
            m_last_reg   <= 1'b0;
            m_value_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            sp_reg       <= sp_next;
            lo_reg       <= lo_next;
            hi_reg       <= hi_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            pivot_reg    <= pivot_next;
            vi_reg       <= vi_next;
            vj_reg       <= vj_next;
            cmp_reg      <= cmp_next;
            mov_reg      <= mov_next;
            k_reg        <= k_next;
            m_tvalid_reg <= m_tvalid_next;
            m_last_reg   <= m_last_next;
            m_value_reg  <= m_value_next;
        end
    end

    // element store
    qsoc_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_ELEMENTS),
        .AW    (AW)
    ) u_elem_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // pending ranges, {hi, lo}
    qsoc_ram #(
        .WIDTH (2 * AW),
        .DEPTH (MAX_ELEMENTS),
        .AW    (AW)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, mov_reg, cmp_reg, m_value_reg};

endmodule
